// File: rtl/bdpe_pkg.sv
// shared types, result codes and constants of the byte difference patch encoder
package bdpe_pkg;

    localparam int BLOCK_BYTES_DEF = 255;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] run_offset;
        logic [7:0]  run_length;
        logic [7:0]  data_byte;
        logic        identical;
    } rec_t;

    // up to three results of one input item, packed from slot 0 upward
    typedef struct packed {
        rec_t [2:0] slot;
        logic [1:0] last_idx;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic rec_t make_rec(
        input logic [1:0]  kind,
        input logic [31:0] off,
        input logic [7:0]  len,
        input logic [7:0]  data,
        input logic        ident
    );
        rec_t r;
        r.kind       = kind;
        r.run_offset = off;
        r.run_length = len;
        r.data_byte  = data;
        r.identical  = ident;
        return r;
    endfunction

endpackage

// File: rtl/bdpe_front.sv
// front part: takes input beats, tracks run state and plans the results of each beat
module bdpe_front #(
    parameter int BLOCK_BYTES = bdpe_pkg::BLOCK_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_orig_byte,
    input  logic [7:0]       s_mod_byte,
    input  logic             s_orig_present,
    input  logic             s_final_position,
    input  bdpe_pkg::q_stat_t q_stat,
    output logic             push,
    output bdpe_pkg::plan_t  push_plan
);
    import bdpe_pkg::*;

    logic [31:0] position_reg, position_next;
    logic [7:0]  block_fill_reg, block_fill_next;
    logic        run_open_reg, run_open_next;
    logic [31:0] run_start_reg, run_start_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic        any_change_reg, any_change_next;
    logic        in_tail_reg, in_tail_next;

    logic        accept;
    logic        tail_start;
    logic        open1;
    logic [7:0]  count1;
    logic [7:0]  fill1;
    logic        differ;
    logic        open2;
    logic [7:0]  count2;
    logic [31:0] start2;
    logic        any2;
    logic [8:0]  fill_inc;
    logic        av, bv, cv;
    rec_t        rec_a, rec_b, rec_c;
    logic [1:0]  n_res;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // tail begins: close any run and restart block counting
        tail_start = !s_orig_present && !in_tail_reg;
        av         = tail_start && run_open_reg;
        rec_a      = make_rec(KIND_HEADER, run_start_reg, run_count_reg, 8'd0, 1'b0);
        open1      = tail_start ? 1'b0 : run_open_reg;
        count1     = tail_start ? 8'd0 : run_count_reg;
        fill1      = tail_start ? 8'd0 : block_fill_reg;

        in_tail_next = in_tail_reg || !s_orig_present;
        differ       = in_tail_next || (s_orig_byte != s_mod_byte);

        if (differ) begin
            start2 = open1 ? run_start_reg : position_reg;
            count2 = (open1 ? count1 : 8'd0) + 8'd1;
            open2  = 1'b1;
            bv     = 1'b1;
            rec_b  = make_rec(KIND_DATA, 32'd0, 8'd0, s_mod_byte, 1'b0);
            any2   = 1'b1;
        end else begin
            start2 = run_start_reg;
            count2 = 8'd0;
            open2  = 1'b0;
            bv     = open1;
            rec_b  = make_rec(KIND_HEADER, run_start_reg, count1, 8'd0, 1'b0);
            any2   = any_change_reg;
        end

        fill_inc = {1'b0, fill1} + 9'd1;

        position_next   = position_reg + 32'd1;
        block_fill_next = fill_inc[7:0];
        run_open_next   = open2;
        run_start_next  = start2;
        run_count_next  = count2;
        any_change_next = any2;
        cv              = 1'b0;
        rec_c           = make_rec(KIND_END, 32'd0, 8'd0, 8'd0, 1'b0);

        if (s_final_position) begin
            // end beat carries the open run, then everything starts over
            cv    = 1'b1;
            rec_c = make_rec(KIND_END, open2 ? start2 : 32'd0, open2 ? count2 : 8'd0,
                             8'd0, !any2);
            position_next   = 32'd0;
            block_fill_next = 8'd0;
            run_open_next   = 1'b0;
            run_start_next  = 32'd0;
            run_count_next  = 8'd0;
            any_change_next = 1'b0;
            in_tail_next    = 1'b0;
        end else if (fill_inc >= 9'(BLOCK_BYTES)) begin
            cv              = open2;
            rec_c           = make_rec(KIND_HEADER, start2, count2, 8'd0, 1'b0);
            run_open_next   = 1'b0;
            run_count_next  = 8'd0;
            block_fill_next = 8'd0;
        end

        n_res = {1'b0, av} + {1'b0, bv} + {1'b0, cv};

        // pack the present results from slot 0 upward
        push_plan.slot[0]  = av ? rec_a : (bv ? rec_b : rec_c);
        push_plan.slot[1]  = (av && bv) ? rec_b : rec_c;
        push_plan.slot[2]  = rec_c;
        push_plan.last_idx = n_res - 2'd1;

        push = accept && (n_res != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= 32'd0;
            block_fill_reg <= 8'd0;
            run_open_reg   <= 1'b0;
            run_start_reg  <= 32'd0;
            run_count_reg  <= 8'd0;
            any_change_reg <= 1'b0;
            in_tail_reg    <= 1'b0;
        end else if (accept) begin
            position_reg   <= position_next;
            block_fill_reg <= block_fill_next;
            run_open_reg   <= run_open_next;
            run_start_reg  <= run_start_next;
            run_count_reg  <= run_count_next;
            any_change_reg <= any_change_next;
            in_tail_reg    <= in_tail_next;
        end
    end

endmodule

// File: rtl/bdpe_queue.sv
// short queue of result plans between the front and back parts
module bdpe_queue #(
    parameter int DEPTH = bdpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bdpe_pkg::plan_t   push_plan,
    input  logic              pop,
    output bdpe_pkg::plan_t   head_plan,
    output bdpe_pkg::q_stat_t q_stat
);
    import bdpe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plan_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_plan    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

// File: rtl/bdpe_back.sv
// back part: walks the planned results of each beat into the output register
module bdpe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  bdpe_pkg::plan_t   head_plan,
    input  bdpe_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [31:0]       m_run_offset,
    output logic [7:0]        m_run_length,
    output logic [7:0]        m_data_byte,
    output logic              m_identical,
    output logic              m_last_of_item
);
    import bdpe_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    rec_t       rec_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = !q_stat.empty && (!valid_reg || m_ready);
    assign at_last = (idx_reg == head_plan.last_idx);
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg  <= head_plan.slot[idx_reg];
            last_reg <= at_last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = rec_reg.kind;
    assign m_run_offset   = rec_reg.run_offset;
    assign m_run_length   = rec_reg.run_length;
    assign m_data_byte    = rec_reg.data_byte;
    assign m_identical    = rec_reg.identical;
    assign m_last_of_item = last_reg;

endmodule

// File: rtl/byte_diff_patch_encoder_core.sv
// top level of the byte difference patch encoder
//
// one input beat per file position: original byte, modified byte, a flag that
// the original still has a byte there and a mark on the last position. each
// beat gives zero to three result beats on the m_ channel: changed data bytes,
// run headers (32-bit offset and length) and one end beat per file pair whose
// identical flag is set when nothing differed. m_last_of_item marks the last
// result of an input beat.
// the front part takes one input beat per cycle while the queue has room and
// plans its results into a short queue; the back part sends one result per
// cycle from a registered output while m_ready is high. a beat's results go
// through the queue, then the output register, one after another, and the
// input keeps flowing until the queue (QUEUE_DEPTH planned beats) fills. when
// the receiver stalls, results wait in the output register and queue and
// s_ready drops only once the queue is full. reset clears the run state, the
// queue and m_valid; the next beat starts a new pair at offset 0.
module byte_diff_patch_encoder_core #(
    parameter int BLOCK_BYTES = bdpe_pkg::BLOCK_BYTES_DEF,
    parameter int QUEUE_DEPTH = bdpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_orig_byte,
    input  logic [7:0]  s_mod_byte,
    input  logic        s_orig_present,
    input  logic        s_final_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_run_offset,
    output logic [7:0]  m_run_length,
    output logic [7:0]  m_data_byte,
    output logic        m_identical,
    output logic        m_last_of_item
);
    import bdpe_pkg::*;

    logic    push;
    plan_t   push_plan;
    logic    pop;
    plan_t   head_plan;
    q_stat_t q_stat;

    bdpe_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_orig_byte     (s_orig_byte),
        .s_mod_byte      (s_mod_byte),
        .s_orig_present  (s_orig_present),
        .s_final_position(s_final_position),
        .q_stat          (q_stat),
        .push            (push),
        .push_plan       (push_plan)
    );

    bdpe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_plan(push_plan),
        .pop      (pop),
        .head_plan(head_plan),
        .q_stat   (q_stat)
    );

    bdpe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_plan     (head_plan),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_run_offset  (m_run_offset),
        .m_run_length  (m_run_length),
        .m_data_byte   (m_data_byte),
        .m_identical   (m_identical),
        .m_last_of_item(m_last_of_item)
    );

    // a planned beat is never dropped on a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("plan pushed into a full queue");

    // the end beat always closes its input beat
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_END) |-> m_last_of_item)
        else $error("end beat not marked last");

    // identical is only ever raised on an end beat
    a_ident_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_identical) |-> (m_kind == KIND_END))
        else $error("identical flag outside an end beat");

    // a data beat never reports a run length
    a_data_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_DATA) |-> (m_run_length == 8'd0))
        else $error("data beat with a run length");

endmodule
